// ===== hdl/tdm_pkg.sv =====
// Shared types and constants for the two-segment data memory.
package tdm_pkg;

    // Segment bounds of the address map
    localparam logic [31:0] DATA_BASE = 32'h1000_0000;
    localparam logic [31:0] STACK_END = 32'h7FFF_FFFF;

    // Byte lanes of one memory row
    localparam int LANES = 4;

    // Access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Access sizes in bytes
    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BELOW    = 3'd1,
        ST_ABOVE    = 3'd2,
        ST_MISALIGN = 3'd3,
        ST_BAD_SIZE = 3'd4,
        ST_UNMAPPED = 3'd5
    } status_t;

    typedef logic [LANES-1:0][7:0] lane_t;

    // Decoded control of one item
    typedef struct packed {
        status_t          status;
        logic             do_write;
        logic             do_read;
        logic             hit_data;
        logic [LANES-1:0] lane_we;
        logic [2:0]       size;
        logic [1:0]       off;
        logic             uns;
    } dec_t;

    // Request to one store
    typedef struct packed {
        logic [LANES-1:0] we;
        logic             re;
        lane_t            wdata;
    } bank_req_t;

endpackage

// ===== hdl/tdm_decode.sv =====
// Address check, store selection and write lane steering for one item.
module tdm_decode
    import tdm_pkg::*;
#(
    parameter int DATA_BYTES  = 4096,
    parameter int STACK_BYTES = 4096,
    localparam int DataRows   = (DATA_BYTES + 3) / 4,
    localparam int StackBase  = int'(STACK_END) - STACK_BYTES,
    localparam int StackRows  = ((int'(STACK_END) - 1) >> 2) - (StackBase >> 2) + 1,
    localparam int DataRowW   = $clog2(DataRows),
    localparam int StackRowW  = $clog2(StackRows)
) (
    input  logic                 func,
    input  logic [31:0]          address,
    input  logic [2:0]           size_bytes,
    input  logic                 zero_ext,
    input  logic [31:0]          write_value,
    input  logic                 big_endian,
    output dec_t                 dec,
    output logic [DataRowW-1:0]  data_row,
    output logic [StackRowW-1:0] stack_row,
    output lane_t                lane_data
);

    localparam logic [29:0] StackBaseWord = 30'(StackBase >> 2);

    logic [32:0]      end_sum;
    logic [31:0]      data_off;
    logic [32:0]      data_end;
    logic [29:0]      stack_word;
    logic             below;
    logic             above;
    logic             bad_size;
    logic             misalign;
    logic             in_data;
    logic             in_stack;
    logic             ok;
    status_t          status;
    logic [LANES-1:0] lane_we;

    // Range and alignment checks
    always_comb begin
        end_sum    = {1'b0, address} + {30'd0, size_bytes};
        data_off   = address - DATA_BASE;
        data_end   = {1'b0, data_off} + {30'd0, size_bytes};
        stack_word = address[31:2] - StackBaseWord;
        below      = address < DATA_BASE;
        above      = end_sum >= {1'b0, STACK_END};
        bad_size   = !(size_bytes == SIZE_BYTE || size_bytes == SIZE_HALF ||
                       size_bytes == SIZE_WORD);
        case (size_bytes)
            SIZE_HALF: misalign = address[0];
            SIZE_WORD: misalign = |address[1:0];
            default:   misalign = 1'b0;
        endcase
        in_data  = data_end <= 33'(DATA_BYTES);
        in_stack = address >= 32'(StackBase);
    end

    // Pick the first failing check
    always_comb begin
        if (below) begin
            status = ST_BELOW;
        end else if (above) begin
            status = ST_ABOVE;
        end else if (bad_size) begin
            status = ST_BAD_SIZE;
        end else if (misalign) begin
            status = ST_MISALIGN;
        end else if (!in_data && !in_stack) begin
            status = ST_UNMAPPED;
        end else begin
            status = ST_OK;
        end
        ok = (status == ST_OK);
    end

    // Steer write bytes onto the lanes in the configured byte order
    always_comb begin
        case (size_bytes)
            SIZE_BYTE: begin
                lane_we   = 4'b0001 << address[1:0];
                lane_data = {4{write_value[7:0]}};
            end
            SIZE_HALF: begin
                lane_we = address[1] ? 4'b1100 : 4'b0011;
                if (big_endian) begin
                    lane_data = {write_value[7:0], write_value[15:8],
                                 write_value[7:0], write_value[15:8]};
                end else begin
                    lane_data = {write_value[15:8], write_value[7:0],
                                 write_value[15:8], write_value[7:0]};
                end
            end
            SIZE_WORD: begin
                lane_we = 4'b1111;
                if (big_endian) begin
                    lane_data = {write_value[7:0], write_value[15:8],
                                 write_value[23:16], write_value[31:24]};
                end else begin
                    lane_data = write_value;
                end
            end
            default: begin
                lane_we   = '0;
                lane_data = '0;
            end
        endcase
    end

    // Pack the control of the item
    always_comb begin
        dec.status   = status;
        dec.do_write = ok && (func == FUNC_WRITE);
        dec.do_read  = ok && (func == FUNC_READ);
        dec.hit_data = in_data;
        dec.lane_we  = (ok && (func == FUNC_WRITE)) ? lane_we : '0;
        dec.size     = size_bytes;
        dec.off      = address[1:0];
        dec.uns      = zero_ext;
    end

    assign data_row  = data_off[DataRowW+1:2];
    assign stack_row = stack_word[StackRowW-1:0];

endmodule

// ===== hdl/tdm_bank.sv =====
// One byte store organized as rows of four byte lanes with registered read.
module tdm_bank
    import tdm_pkg::*;
#(
    parameter int ROWS = 1024,
    localparam int RowW = $clog2(ROWS)
) (
    input  logic            aclk,
    input  bank_req_t       req,
    input  logic [RowW-1:0] row,
    output lane_t           rdata
);

    lane_t mem [ROWS];
    lane_t rdata_reg;

    // Write enabled lanes, register the read row
    always_ff @(posedge aclk) begin
        for (int l = 0; l < LANES; l++) begin
            if (req.we[l]) begin
                mem[row][l] <= req.wdata[l];
            end
        end
        if (req.re) begin
            rdata_reg <= mem[row];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tdm_format.sv =====
// Assembles and extends the read value from the four lane bytes.
module tdm_format
    import tdm_pkg::*;
(
    input  lane_t       lanes,
    input  dec_t        dec,
    input  logic        big_endian,
    output logic [31:0] rdata
);

    logic [7:0]  p0;
    logic [7:0]  p1;
    logic [15:0] half;
    logic [7:0]  byte_v;

    // Order bytes, then sign or zero extend
    always_comb begin
        p0     = dec.off[1] ? lanes[2] : lanes[0];
        p1     = dec.off[1] ? lanes[3] : lanes[1];
        half   = big_endian ? {p0, p1} : {p1, p0};
        byte_v = lanes[dec.off];
        rdata  = '0;
        if (dec.do_read) begin
            case (dec.size)
                SIZE_BYTE: rdata = {{24{byte_v[7] & !dec.uns}}, byte_v};
                SIZE_HALF: rdata = {{16{half[15] & !dec.uns}}, half};
                SIZE_WORD: begin
                    if (big_endian) begin
                        rdata = {lanes[0], lanes[1], lanes[2], lanes[3]};
                    end else begin
                        rdata = {lanes[3], lanes[2], lanes[1], lanes[0]};
                    end
                end
                default:   rdata = '0;
            endcase
        end
    end

endmodule

// ===== hdl/two_segment_data_memory_top.sv =====
// Top level of the two-segment data memory: pipeline, clearing pass and stores.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  func, address, size_bytes, zero_ext, write_value
//  m_       out        m_valid / m_ready  read_data, status
//  cfg_     in         cfg_we             cfg_wdata (byte order, 1 = big endian)
//
// One item per cycle while m_ready does not stall the result. An accepted item passes
// the decode register, the store access with registered read row and the result
// register, and then m_valid rises. The single row port of each store and its read
// register set the latency. After reset a clearing pass zeroes both stores, one row a
// cycle, over max(ceil(DATA_BYTES/4), stack rows) rows; s_ready stays low meanwhile.
// A stalled result holds its stage; earlier stages keep filling until each is full.
module two_segment_data_memory_top
    import tdm_pkg::*;
#(
    parameter int DATA_BYTES  = 4096,
    parameter int STACK_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_address,
    input  logic [2:0]  s_size_bytes,
    input  logic        s_zero_ext,
    input  logic [31:0] s_write_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic [2:0]  m_status,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    localparam int DataRows  = (DATA_BYTES + 3) / 4;
    localparam int StackBase = int'(STACK_END) - STACK_BYTES;
    localparam int StackRows = ((int'(STACK_END) - 1) >> 2) - (StackBase >> 2) + 1;
    localparam int DataRowW  = $clog2(DataRows);
    localparam int StackRowW = $clog2(StackRows);
    localparam int MaxRows   = (DataRows > StackRows) ? DataRows : StackRows;
    localparam int ClrW      = $clog2(MaxRows);

    // Configuration
    logic big_endian_reg;
    logic big_endian_next;

    // Clearing pass
    logic            clr_reg;
    logic            clr_next;
    logic [ClrW-1:0] clr_row_reg;
    logic [ClrW-1:0] clr_row_next;
    logic            clr_in_data;
    logic            clr_in_stack;

    // Decode stage
    logic                 a_valid_reg;
    logic                 a_valid_next;
    dec_t                 a_dec_reg;
    logic [DataRowW-1:0]  a_drow_reg;
    logic [StackRowW-1:0] a_srow_reg;
    lane_t                a_wdata_reg;

    // Store access stage
    logic b_valid_reg;
    logic b_valid_next;
    dec_t b_dec_reg;

    // Result stage
    logic        c_valid_reg;
    logic        c_valid_next;
    logic [31:0] c_rdata_reg;
    status_t     c_status_reg;

    // Stage enables
    logic en_a;
    logic en_b;
    logic en_c;
    logic s_accept;
    logic a_go;

    // Decode outputs
    dec_t                 dec;
    logic [DataRowW-1:0]  dec_drow;
    logic [StackRowW-1:0] dec_srow;
    lane_t                dec_wdata;

    // Store ports
    bank_req_t            data_req;
    bank_req_t            stack_req;
    logic [DataRowW-1:0]  data_row;
    logic [StackRowW-1:0] stack_row;
    lane_t                data_rdata;
    lane_t                stack_rdata;
    lane_t                b_lanes;
    logic [31:0]          fmt_rdata;

    tdm_decode #(
        .DATA_BYTES (DATA_BYTES),
        .STACK_BYTES(STACK_BYTES)
    ) u_decode (
        .func         (s_func),
        .address      (s_address),
        .size_bytes   (s_size_bytes),
        .zero_ext     (s_zero_ext),
        .write_value  (s_write_value),
        .big_endian   (big_endian_reg),
        .dec          (dec),
        .data_row     (dec_drow),
        .stack_row    (dec_srow),
        .lane_data    (dec_wdata)
    );

    // Advance a stage when the one after it can take its item
    always_comb begin
        en_c     = !c_valid_reg || m_ready;
        en_b     = !b_valid_reg || en_c;
        en_a     = !a_valid_reg || en_b;
        s_ready  = en_a && !clr_reg;
        s_accept = s_valid && s_ready;
        a_go     = a_valid_reg && en_b;
    end

    // Next state of control registers
    always_comb begin
        big_endian_next = cfg_we ? cfg_wdata : big_endian_reg;
        clr_next        = clr_reg;
        clr_row_next    = clr_row_reg;
        if (clr_reg) begin
            if (clr_row_reg == ClrW'(MaxRows - 1)) begin
                clr_next = 1'b0;
            end else begin
                clr_row_next = clr_row_reg + ClrW'(1);
            end
        end
        a_valid_next = en_a ? s_accept : a_valid_reg;
        b_valid_next = en_b ? a_valid_reg : b_valid_reg;
        c_valid_next = en_c ? b_valid_reg : c_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg <= 1'b1;
            clr_reg        <= 1'b1;
            clr_row_reg    <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
        end else begin
            big_endian_reg <= big_endian_next;
            clr_reg        <= clr_next;
            clr_row_reg    <= clr_row_next;
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
            c_valid_reg    <= c_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_dec_reg   <= dec;
            a_drow_reg  <= dec_drow;
            a_srow_reg  <= dec_srow;
            a_wdata_reg <= dec_wdata;
        end
        if (en_b) begin
            b_dec_reg <= a_dec_reg;
        end
        if (en_c) begin
            c_rdata_reg  <= fmt_rdata;
            c_status_reg <= b_dec_reg.status;
        end
    end

    // Drive store ports from the clearing pass or the decoded item
    always_comb begin
        clr_in_data  = {1'b0, clr_row_reg} < (ClrW + 1)'(DataRows);
        clr_in_stack = {1'b0, clr_row_reg} < (ClrW + 1)'(StackRows);
        if (clr_reg) begin
            data_req.we     = clr_in_data ? '1 : '0;
            data_req.re     = 1'b0;
            data_req.wdata  = '0;
            data_row        = clr_row_reg[DataRowW-1:0];
            stack_req.we    = clr_in_stack ? '1 : '0;
            stack_req.re    = 1'b0;
            stack_req.wdata = '0;
            stack_row       = clr_row_reg[StackRowW-1:0];
        end else begin
            data_req.we     = (a_go && a_dec_reg.hit_data) ? a_dec_reg.lane_we : '0;
            data_req.re     = a_go && a_dec_reg.do_read && a_dec_reg.hit_data;
            data_req.wdata  = a_wdata_reg;
            data_row        = a_drow_reg;
            stack_req.we    = (a_go && !a_dec_reg.hit_data) ? a_dec_reg.lane_we : '0;
            stack_req.re    = a_go && a_dec_reg.do_read && !a_dec_reg.hit_data;
            stack_req.wdata = a_wdata_reg;
            stack_row       = a_srow_reg;
        end
    end

    tdm_bank #(
        .ROWS(DataRows)
    ) u_data_bank (
        .aclk (aclk),
        .req  (data_req),
        .row  (data_row),
        .rdata(data_rdata)
    );

    tdm_bank #(
        .ROWS(StackRows)
    ) u_stack_bank (
        .aclk (aclk),
        .req  (stack_req),
        .row  (stack_row),
        .rdata(stack_rdata)
    );

    // Format the read value of the item in the access stage
    assign b_lanes = b_dec_reg.hit_data ? data_rdata : stack_rdata;

    tdm_format u_format (
        .lanes     (b_lanes),
        .dec       (b_dec_reg),
        .big_endian(big_endian_reg),
        .rdata     (fmt_rdata)
    );

    assign m_valid     = c_valid_reg;
    assign m_read_data = c_rdata_reg;
    assign m_status    = c_status_reg;

    // No item is taken while the stores are being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_reg |-> !s_ready)
        else $error("item accepted during clearing pass");

    // A failed access returns zero data
    a_error_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_read_data == 32'd0))
        else $error("nonzero read data with error status");

    // The clearing pass ends after its last row
    a_clear_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (clr_reg && clr_row_reg == ClrW'(MaxRows - 1)) |=> !clr_reg)
        else $error("clearing pass did not end");

    // Stores are never written outside the clearing pass without a checked item
    a_write_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (!clr_reg && ((|data_req.we) || (|stack_req.we))) |->
            (a_go && a_dec_reg.status == ST_OK))
        else $error("store write without a valid item");

endmodule

// ===== dv/two_segment_data_memory_top_tb.sv =====
// Two-segment data memory testbench: directed and random accesses checked against a byte mirror.
`timescale 1ns / 1ps

module two_segment_data_memory_top_tb
    import tdm_pkg::*;
();

    localparam int DATA_BYTES  = 4096;
    localparam int STACK_BYTES = 4096;
    localparam logic [31:0] STACK_BASE = STACK_END - STACK_BYTES;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic        func;
        logic [31:0] address;
        logic [2:0]  size_bytes;
        logic        zero_ext;
        logic [31:0] write_value;
        int          gap;
    } access_t;

    typedef struct {
        logic [31:0] read_data;
        status_t     status;
    } mem_reply_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = 1'b0;
    logic [31:0] s_address = '0;
    logic [2:0]  s_size_bytes = '0;
    logic        s_zero_ext = 1'b0;
    logic [31:0] s_write_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_data;
    logic [2:0]  m_status;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;

    // Mirror of both stores and of the byte order
    logic [7:0]  data_mirror [DATA_BYTES];
    logic [7:0]  stack_mirror [STACK_BYTES];
    logic        mirror_big = 1'b1;

    access_t     access_q[$];
    mem_reply_t  mem_reply_q[$];
    access_t     cur;
    int          gap_left = 0;
    int          stall_left = 0;
    int          replies_seen = 0;
    int          err_count = 0;
    int          cycle_count = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    bit          hold_done = 1'b0;

    two_segment_data_memory_top #(
        .DATA_BYTES (DATA_BYTES),
        .STACK_BYTES(STACK_BYTES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_address      (s_address),
        .s_size_bytes   (s_size_bytes),
        .s_zero_ext     (s_zero_ext),
        .s_write_value  (s_write_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_status       (m_status),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Decode one access, update the mirror and return the reply it should produce
    function automatic mem_reply_t apply_access(input access_t it);
        mem_reply_t  r;
        logic [63:0] a;
        logic [31:0] v;
        int          n;
        int          idx;
        int          pos;
        bit          in_data;
        r.read_data = '0;
        r.status = ST_OK;
        a = {32'd0, it.address};
        n = int'(it.size_bytes);
        in_data = 1'b0;
        idx = 0;
        if (a < 64'(DATA_BASE)) begin
            r.status = ST_BELOW;
        end else if (a + 64'(n) >= 64'(STACK_END)) begin
            r.status = ST_ABOVE;
        end else if (it.size_bytes != SIZE_BYTE && it.size_bytes != SIZE_HALF &&
                     it.size_bytes != SIZE_WORD) begin
            r.status = ST_BAD_SIZE;
        end else if ((it.address & (32'(n) - 32'd1)) != 0) begin
            r.status = ST_MISALIGN;
        end else if (a - 64'(DATA_BASE) + 64'(n) <= 64'(DATA_BYTES)) begin
            in_data = 1'b1;
            idx = int'(a - 64'(DATA_BASE));
        end else if (a >= 64'(STACK_BASE)) begin
            idx = int'(a - 64'(STACK_BASE));
        end else begin
            r.status = ST_UNMAPPED;
        end

        if (r.status == ST_OK && it.func == FUNC_WRITE) begin
            // lay the low n bytes out in the configured byte order
            for (int b = 0; b < n; b++) begin
                pos = mirror_big ? n - 1 - b : b;
                if (in_data) data_mirror[idx + pos] = it.write_value[8*b +: 8];
                else stack_mirror[idx + pos] = it.write_value[8*b +: 8];
            end
        end else if (r.status == ST_OK) begin
            v = '0;
            for (int b = 0; b < n; b++) begin
                pos = mirror_big ? b : n - 1 - b;
                v = {v[23:0], in_data ? data_mirror[idx + pos] : stack_mirror[idx + pos]};
            end
            // extend the sign of short loads unless asked for zeros
            if (!it.zero_ext && n < 4 && v[8*n-1]) v = v | ~((32'd1 << (8*n)) - 32'd1);
            r.read_data = v;
        end
        return r;
    endfunction

    // Queue one access with the gap that follows it; switch between bursts and idling now and then
    task automatic queue_access(input logic f, input logic [31:0] a, input logic [2:0] sz,
                                input logic u, input logic [31:0] wv);
        access_t it;
        if ($urandom_range(39, 0) == 0) tx_burst = !tx_burst;
        it.func = f;
        it.address = a;
        it.size_bytes = sz;
        it.zero_ext = u;
        it.write_value = wv;
        it.gap = tx_burst ? 0 : $urandom_range(16, 0);
        access_q.push_back(it);
    endtask

    // Mostly well-formed loads and stores in both segments, the rest near edges or random
    task automatic queue_random(input int count);
        int          sel;
        logic [2:0]  sz;
        logic [31:0] off;
        logic [31:0] a;
        repeat (count) begin
            sel = $urandom_range(99, 0);
            case ($urandom_range(2, 0))
                0: sz = SIZE_BYTE;
                1: sz = SIZE_HALF;
                default: sz = SIZE_WORD;
            endcase
            if (sel < 85) begin
                if (sel < 45) begin
                    // keep most data accesses in a small window so loads see recent stores
                    off = ($urandom_range(2, 0) != 0) ? $urandom_range(31, 0)
                                                      : $urandom_range(DATA_BYTES - 1, 0);
                    a = DATA_BASE + (off & ~(32'(sz) - 32'd1));
                end else if (sz == SIZE_BYTE && $urandom_range(31, 0) == 0) begin
                    a = STACK_BASE;
                end else begin
                    // whole access must end below the last stack byte
                    off = ($urandom_range(2, 0) != 0)
                        ? $urandom_range(STACK_BYTES - 2 - sz, STACK_BYTES - 64)
                        : $urandom_range(STACK_BYTES - 2 - sz, 0);
                    a = (STACK_BASE + 32'd1 + off) & ~(32'(sz) - 32'd1);
                end
                queue_access(1'($urandom_range(1, 0)), a, sz, 1'($urandom_range(1, 0)),
                             $urandom);
            end else begin
                case ($urandom_range(5, 0))
                    0: a = $urandom;
                    1: a = DATA_BASE - 32'd8 + $urandom_range(15, 0);
                    2: a = DATA_BASE + DATA_BYTES - 32'd8 + $urandom_range(15, 0);
                    3: a = STACK_BASE - 32'd8 + $urandom_range(15, 0);
                    4: a = STACK_END - 32'd8 + $urandom_range(15, 0);
                    default: a = DATA_BASE + $urandom_range(63, 0);
                endcase
                queue_access(1'($urandom_range(1, 0)), a, 3'($urandom_range(7, 0)),
                             1'($urandom_range(1, 0)), $urandom);
            end
        end
    endtask

    // Wait until every queued access is sent and every reply is back
    task automatic drain_replies();
        while (access_q.size() != 0 || s_valid || mem_reply_q.size() != 0) @(negedge aclk);
    endtask

    // Write the byte order while the block is idle
    task automatic set_byte_order(input logic big);
        drain_replies();
        repeat (6) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= big;
        @(posedge aclk);
        cfg_we <= 1'b0;
        mirror_big = big;
        @(negedge aclk);
    endtask

    // Sender: launch the next access when the slot frees up, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) mem_reply_q.push_back(apply_access(cur));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (access_q.size() != 0) begin
                    cur = access_q.pop_front();
                    s_valid <= 1'b1;
                    s_func <= cur.func;
                    s_address <= cur.address;
                    s_size_bytes <= cur.size_bytes;
                    s_zero_ext <= cur.zero_ext;
                    s_write_value <= cur.write_value;
                    gap_left = cur.gap;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each reply against the oldest prediction, then draw the next stall
    always @(posedge aclk) begin
        mem_reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (mem_reply_q.size() == 0) begin
                    $error("unexpected reply: read_data %h status %0d", m_read_data, m_status);
                    err_count++;
                end else begin
                    want = mem_reply_q.pop_front();
                    if (m_read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h", want.read_data, m_read_data);
                        err_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        err_count++;
                    end
                end
                replies_seen++;
            end
            // hold off once for a long stretch so the pipeline backs up into s_ready
            if (!hold_done && replies_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (m_valid && m_ready) begin
                if ($urandom_range(39, 0) == 0) rx_burst = !rx_burst;
                stall_left = rx_burst ? 0 : $urandom_range(16, 0);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        foreach (data_mirror[i]) data_mirror[i] = 8'h00;
        foreach (stack_mirror[i]) stack_mirror[i] = 8'h00;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        set_byte_order(1'b1);

        // Directed: byte lanes, sign handling, segment edges and each error kind
        queue_access(FUNC_WRITE, DATA_BASE, SIZE_WORD, 1'b0, 32'h8899_AABB);
        queue_access(FUNC_READ, DATA_BASE, SIZE_WORD, 1'b0, 32'h0);
        queue_access(FUNC_READ, DATA_BASE, SIZE_BYTE, 1'b0, 32'h0);
        queue_access(FUNC_READ, DATA_BASE + 32'd3, SIZE_BYTE, 1'b1, 32'h0);
        queue_access(FUNC_READ, DATA_BASE + 32'd2, SIZE_HALF, 1'b0, 32'h0);
        queue_access(FUNC_READ, DATA_BASE, SIZE_HALF, 1'b1, 32'h0);
        queue_access(FUNC_WRITE, DATA_BASE + DATA_BYTES - 1, SIZE_BYTE, 1'b0, 32'hFFFF_FF7F);
        queue_access(FUNC_READ, DATA_BASE + DATA_BYTES - 1, SIZE_BYTE, 1'b0, 32'h0);
        queue_access(FUNC_READ, DATA_BASE + DATA_BYTES - 4, SIZE_WORD, 1'b0, 32'h0);
        queue_access(FUNC_READ, DATA_BASE + DATA_BYTES, SIZE_BYTE, 1'b0, 32'h0);
        queue_access(FUNC_WRITE, 32'h4000_0000, SIZE_WORD, 1'b0, 32'hFFFF_FFFF);
        queue_access(FUNC_WRITE, STACK_BASE, SIZE_BYTE, 1'b0, 32'hFFFF_FF80);
        queue_access(FUNC_READ, STACK_BASE, SIZE_BYTE, 1'b0, 32'h0);
        queue_access(FUNC_WRITE, STACK_END - 32'd3, SIZE_HALF, 1'b0, 32'h0000_F234);
        queue_access(FUNC_READ, STACK_END - 32'd3, SIZE_HALF, 1'b0, 32'h0);
        queue_access(FUNC_READ, STACK_END - 32'd2, SIZE_BYTE, 1'b1, 32'h0);
        queue_access(FUNC_READ, STACK_END - 32'd1, SIZE_BYTE, 1'b0, 32'h0);
        queue_access(FUNC_READ, STACK_END - 32'd3, SIZE_WORD, 1'b0, 32'h0);
        queue_access(FUNC_READ, DATA_BASE - 32'd1, SIZE_BYTE, 1'b0, 32'h0);
        queue_access(FUNC_WRITE, 32'h0000_0000, SIZE_WORD, 1'b0, 32'h1234_5678);
        queue_access(FUNC_READ, 32'hFFFF_FFFF, 3'd7, 1'b1, 32'h0);
        queue_access(FUNC_READ, DATA_BASE, 3'd0, 1'b0, 32'h0);
        queue_access(FUNC_WRITE, DATA_BASE, 3'd3, 1'b0, 32'h0);
        queue_access(FUNC_WRITE, DATA_BASE + 32'd2, SIZE_WORD, 1'b0, 32'hDEAD_BEEF);
        queue_access(FUNC_READ, DATA_BASE + 32'd1, SIZE_HALF, 1'b0, 32'h0);
        queue_random(600);

        // Little endian, then back to big, then little again
        set_byte_order(1'b0);
        queue_random(700);
        set_byte_order(1'b1);
        queue_random(400);
        set_byte_order(1'b0);
        queue_random(300);

        drain_replies();
        repeat (10) @(posedge aclk);
        if (err_count == 0 && mem_reply_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tdm_pkg.sv
hdl/tdm_decode.sv
hdl/tdm_bank.sv
hdl/tdm_format.sv
hdl/two_segment_data_memory_top.sv
dv/two_segment_data_memory_top_tb.sv
